[hw/rtl/gn3_pkg.sv]
// ----------------------------------------------------------------------------
// gn3_pkg: shared constants and table for the 3d gradient noise block
// permutation table, widths
// ----------------------------------------------------------------------------
package gn3_pkg;

  localparam int unsigned FracBitsDef    = 16;
  localparam int unsigned LatticeBitsDef = 8;
  localparam int unsigned CoordW         = 24;
  localparam int unsigned OutW           = 18;
  localparam int unsigned OutFrac        = 16;
  localparam int unsigned QueueDepth     = 4;

  function automatic logic [7:0] perm(input logic [7:0] i);
    logic [7:0] r;
    unique case (i)
      8'd0: r = 8'd151; 8'd1: r = 8'd160; 8'd2: r = 8'd137; 8'd3: r = 8'd91;
      8'd4: r = 8'd90; 8'd5: r = 8'd15; 8'd6: r = 8'd131; 8'd7: r = 8'd13;
      8'd8: r = 8'd201; 8'd9: r = 8'd95; 8'd10: r = 8'd96; 8'd11: r = 8'd53;
      8'd12: r = 8'd194; 8'd13: r = 8'd233; 8'd14: r = 8'd7; 8'd15: r = 8'd225;
      8'd16: r = 8'd140; 8'd17: r = 8'd36; 8'd18: r = 8'd103; 8'd19: r = 8'd30;
      8'd20: r = 8'd69; 8'd21: r = 8'd142; 8'd22: r = 8'd8; 8'd23: r = 8'd99;
      8'd24: r = 8'd37; 8'd25: r = 8'd240; 8'd26: r = 8'd21; 8'd27: r = 8'd10;
      8'd28: r = 8'd23; 8'd29: r = 8'd190; 8'd30: r = 8'd6; 8'd31: r = 8'd148;
      8'd32: r = 8'd247; 8'd33: r = 8'd120; 8'd34: r = 8'd234; 8'd35: r = 8'd75;
      8'd36: r = 8'd0; 8'd37: r = 8'd26; 8'd38: r = 8'd197; 8'd39: r = 8'd62;
      8'd40: r = 8'd94; 8'd41: r = 8'd252; 8'd42: r = 8'd219; 8'd43: r = 8'd203;
      8'd44: r = 8'd117; 8'd45: r = 8'd35; 8'd46: r = 8'd11; 8'd47: r = 8'd32;
      8'd48: r = 8'd57; 8'd49: r = 8'd177; 8'd50: r = 8'd33; 8'd51: r = 8'd88;
      8'd52: r = 8'd237; 8'd53: r = 8'd149; 8'd54: r = 8'd56; 8'd55: r = 8'd87;
      8'd56: r = 8'd174; 8'd57: r = 8'd20; 8'd58: r = 8'd125; 8'd59: r = 8'd136;
      8'd60: r = 8'd171; 8'd61: r = 8'd168; 8'd62: r = 8'd68; 8'd63: r = 8'd175;
      8'd64: r = 8'd74; 8'd65: r = 8'd165; 8'd66: r = 8'd71; 8'd67: r = 8'd134;
      8'd68: r = 8'd139; 8'd69: r = 8'd48; 8'd70: r = 8'd27; 8'd71: r = 8'd166;
      8'd72: r = 8'd77; 8'd73: r = 8'd146; 8'd74: r = 8'd158; 8'd75: r = 8'd231;
      8'd76: r = 8'd83; 8'd77: r = 8'd111; 8'd78: r = 8'd229; 8'd79: r = 8'd122;
      8'd80: r = 8'd60; 8'd81: r = 8'd211; 8'd82: r = 8'd133; 8'd83: r = 8'd230;
      8'd84: r = 8'd220; 8'd85: r = 8'd105; 8'd86: r = 8'd92; 8'd87: r = 8'd41;
      8'd88: r = 8'd55; 8'd89: r = 8'd46; 8'd90: r = 8'd245; 8'd91: r = 8'd40;
      8'd92: r = 8'd244; 8'd93: r = 8'd102; 8'd94: r = 8'd143; 8'd95: r = 8'd54;
      8'd96: r = 8'd65; 8'd97: r = 8'd25; 8'd98: r = 8'd63; 8'd99: r = 8'd161;
      8'd100: r = 8'd1; 8'd101: r = 8'd216; 8'd102: r = 8'd80; 8'd103: r = 8'd73;
      8'd104: r = 8'd209; 8'd105: r = 8'd76; 8'd106: r = 8'd132; 8'd107: r = 8'd187;
      8'd108: r = 8'd208; 8'd109: r = 8'd89; 8'd110: r = 8'd18; 8'd111: r = 8'd169;
      8'd112: r = 8'd200; 8'd113: r = 8'd196; 8'd114: r = 8'd135; 8'd115: r = 8'd130;
      8'd116: r = 8'd116; 8'd117: r = 8'd188; 8'd118: r = 8'd159; 8'd119: r = 8'd86;
      8'd120: r = 8'd164; 8'd121: r = 8'd100; 8'd122: r = 8'd109; 8'd123: r = 8'd198;
      8'd124: r = 8'd173; 8'd125: r = 8'd186; 8'd126: r = 8'd3; 8'd127: r = 8'd64;
      8'd128: r = 8'd52; 8'd129: r = 8'd217; 8'd130: r = 8'd226; 8'd131: r = 8'd250;
      8'd132: r = 8'd124; 8'd133: r = 8'd123; 8'd134: r = 8'd5; 8'd135: r = 8'd202;
      8'd136: r = 8'd38; 8'd137: r = 8'd147; 8'd138: r = 8'd118; 8'd139: r = 8'd126;
      8'd140: r = 8'd255; 8'd141: r = 8'd82; 8'd142: r = 8'd85; 8'd143: r = 8'd212;
      8'd144: r = 8'd207; 8'd145: r = 8'd206; 8'd146: r = 8'd59; 8'd147: r = 8'd227;
      8'd148: r = 8'd47; 8'd149: r = 8'd16; 8'd150: r = 8'd58; 8'd151: r = 8'd17;
      8'd152: r = 8'd182; 8'd153: r = 8'd189; 8'd154: r = 8'd28; 8'd155: r = 8'd42;
      8'd156: r = 8'd223; 8'd157: r = 8'd183; 8'd158: r = 8'd170; 8'd159: r = 8'd213;
      8'd160: r = 8'd119; 8'd161: r = 8'd248; 8'd162: r = 8'd152; 8'd163: r = 8'd2;
      8'd164: r = 8'd44; 8'd165: r = 8'd154; 8'd166: r = 8'd163; 8'd167: r = 8'd70;
      8'd168: r = 8'd221; 8'd169: r = 8'd153; 8'd170: r = 8'd101; 8'd171: r = 8'd155;
      8'd172: r = 8'd167; 8'd173: r = 8'd43; 8'd174: r = 8'd172; 8'd175: r = 8'd9;
      8'd176: r = 8'd129; 8'd177: r = 8'd22; 8'd178: r = 8'd39; 8'd179: r = 8'd253;
      8'd180: r = 8'd19; 8'd181: r = 8'd98; 8'd182: r = 8'd108; 8'd183: r = 8'd110;
      8'd184: r = 8'd79; 8'd185: r = 8'd113; 8'd186: r = 8'd224; 8'd187: r = 8'd232;
      8'd188: r = 8'd178; 8'd189: r = 8'd185; 8'd190: r = 8'd112; 8'd191: r = 8'd104;
      8'd192: r = 8'd218; 8'd193: r = 8'd246; 8'd194: r = 8'd97; 8'd195: r = 8'd228;
      8'd196: r = 8'd251; 8'd197: r = 8'd34; 8'd198: r = 8'd242; 8'd199: r = 8'd193;
      8'd200: r = 8'd238; 8'd201: r = 8'd210; 8'd202: r = 8'd144; 8'd203: r = 8'd12;
      8'd204: r = 8'd191; 8'd205: r = 8'd179; 8'd206: r = 8'd162; 8'd207: r = 8'd241;
      8'd208: r = 8'd81; 8'd209: r = 8'd51; 8'd210: r = 8'd145; 8'd211: r = 8'd235;
      8'd212: r = 8'd249; 8'd213: r = 8'd14; 8'd214: r = 8'd239; 8'd215: r = 8'd107;
      8'd216: r = 8'd49; 8'd217: r = 8'd192; 8'd218: r = 8'd214; 8'd219: r = 8'd31;
      8'd220: r = 8'd181; 8'd221: r = 8'd199; 8'd222: r = 8'd106; 8'd223: r = 8'd157;
      8'd224: r = 8'd184; 8'd225: r = 8'd84; 8'd226: r = 8'd204; 8'd227: r = 8'd176;
      8'd228: r = 8'd115; 8'd229: r = 8'd121; 8'd230: r = 8'd50; 8'd231: r = 8'd45;
      8'd232: r = 8'd127; 8'd233: r = 8'd4; 8'd234: r = 8'd150; 8'd235: r = 8'd254;
      8'd236: r = 8'd138; 8'd237: r = 8'd236; 8'd238: r = 8'd205; 8'd239: r = 8'd93;
      8'd240: r = 8'd222; 8'd241: r = 8'd114; 8'd242: r = 8'd67; 8'd243: r = 8'd29;
      8'd244: r = 8'd24; 8'd245: r = 8'd72; 8'd246: r = 8'd243; 8'd247: r = 8'd141;
      8'd248: r = 8'd128; 8'd249: r = 8'd195; 8'd250: r = 8'd78; 8'd251: r = 8'd66;
      8'd252: r = 8'd215; 8'd253: r = 8'd61; 8'd254: r = 8'd156; 8'd255: r = 8'd180;
      default: r = 8'd0;
    endcase
    return r;
  endfunction

endpackage

[hw/rtl/gn3_front.sv]
// ----------------------------------------------------------------------------
// gn3_front: lattice hash front end
// splits coordinates, hashes the 8 corners over three registered levels
// ----------------------------------------------------------------------------
module gn3_front import gn3_pkg::*; #(
  parameter int unsigned FRAC_BITS = FracBitsDef
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [CoordW-1:0]    in_coord_x,
  input  logic [CoordW-1:0]    in_coord_y,
  input  logic [CoordW-1:0]    in_coord_z,
  output logic                 f_valid,
  input  logic                 f_stall,
  output logic [FRAC_BITS-1:0] f_fx,
  output logic [FRAC_BITS-1:0] f_fy,
  output logic [FRAC_BITS-1:0] f_fz,
  output logic [7:0]           f_hash [8]
);

  localparam int unsigned FW   = FRAC_BITS;

  // cell index wraps mod 256; all fraction bits means cell 0
  function automatic logic [7:0] cell_of(input logic [CoordW-1:0] c);
    return 8'(c >> FW);
  endfunction

  logic          v0_r, v1_r, v2_r;
  logic [FW-1:0] fx0_r, fy0_r, fz0_r, fx1_r, fy1_r, fz1_r, fx2_r, fy2_r, fz2_r;
  logic [7:0]    cy0_r, cz0_r, cz1_r;
  logic [7:0]    a0_r, b0_r;
  logic [7:0]    aa_r, ab_r, ba_r, bb_r;
  logic [7:0]    hash_r [8];
  logic          adv;
  logic [7:0]    cx_s;

  // whole pipe moves together; it halts only on downstream stall
  assign adv      = !(v2_r && f_stall);
  assign in_stall = !adv;
  assign cx_s     = cell_of(in_coord_x);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else if (adv) begin
      v0_r <= in_valid;
      v1_r <= v0_r;
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      fx0_r <= in_coord_x[FW-1:0];
      fy0_r <= in_coord_y[FW-1:0];
      fz0_r <= in_coord_z[FW-1:0];
      cy0_r <= cell_of(in_coord_y);
      cz0_r <= cell_of(in_coord_z);
      a0_r  <= perm(cx_s);
      b0_r  <= perm(cx_s + 8'd1);
      fx1_r <= fx0_r; fy1_r <= fy0_r; fz1_r <= fz0_r; cz1_r <= cz0_r;
      aa_r  <= perm(a0_r + cy0_r) + cz0_r;
      ab_r  <= perm(a0_r + cy0_r + 8'd1) + cz0_r;
      ba_r  <= perm(b0_r + cy0_r) + cz0_r;
      bb_r  <= perm(b0_r + cy0_r + 8'd1) + cz0_r;
      fx2_r <= fx1_r; fy2_r <= fy1_r; fz2_r <= fz1_r;
      hash_r[0] <= perm(aa_r);
      hash_r[1] <= perm(ba_r);
      hash_r[2] <= perm(ab_r);
      hash_r[3] <= perm(bb_r);
      hash_r[4] <= perm(aa_r + 8'd1);
      hash_r[5] <= perm(ba_r + 8'd1);
      hash_r[6] <= perm(ab_r + 8'd1);
      hash_r[7] <= perm(bb_r + 8'd1);
    end
  end

  assign f_valid = v2_r;
  assign f_fx    = fx2_r;
  assign f_fy    = fy2_r;
  assign f_fz    = fz2_r;
  assign f_hash  = hash_r;

endmodule

[hw/rtl/gn3_queue.sv]
// ----------------------------------------------------------------------------
// gn3_queue: small fifo between hash front end and arithmetic back end
// ----------------------------------------------------------------------------
module gn3_queue import gn3_pkg::*; #(
  parameter int unsigned W     = 8,
  parameter int unsigned DEPTH = QueueDepth
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         wr_valid,
  output logic         wr_stall,
  input  logic [W-1:0] wr_data,
  output logic         rd_valid,
  input  logic         rd_stall,
  output logic [W-1:0] rd_data
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [W-1:0]  mem [DEPTH];
  logic [AW-1:0] wp_r, rp_r;
  logic [AW:0]   cnt_r;
  logic          wr, rd;

  assign wr_stall = (cnt_r == (AW+1)'(DEPTH));
  assign rd_valid = (cnt_r != '0);
  assign wr       = wr_valid && !wr_stall;
  assign rd       = rd_valid && !rd_stall;
  assign rd_data  = mem[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (wr) wp_r <= (wp_r == AW'(DEPTH-1)) ? '0 : wp_r + AW'(1);
      if (rd) rp_r <= (rp_r == AW'(DEPTH-1)) ? '0 : rp_r + AW'(1);
      cnt_r <= cnt_r + (AW+1)'(wr) - (AW+1)'(rd);
    end
  end

  always_ff @(posedge clk) begin
    if (wr) mem[wp_r] <= wr_data;
  end

endmodule

[hw/rtl/gn3_back.sv]
// ----------------------------------------------------------------------------
// gn3_back: fade, gradient and lerp back end
// fade in three multiply levels, then three lerp levels and output scaling
// ----------------------------------------------------------------------------
module gn3_back import gn3_pkg::*; #(
  parameter int unsigned FRAC_BITS = FracBitsDef
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   b_valid,
  output logic                   b_stall,
  input  logic [FRAC_BITS-1:0]   b_fx,
  input  logic [FRAC_BITS-1:0]   b_fy,
  input  logic [FRAC_BITS-1:0]   b_fz,
  input  logic [7:0]             b_hash [8],
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic signed [OutW-1:0] out_noise_value
);

  localparam int unsigned F  = FRAC_BITS;
  localparam int unsigned TW = F + 2;       // signed offsets t, t-1
  localparam int unsigned VW = F + 3;       // signed dot and lerp values
  localparam int unsigned CW = F + 5;       // signed fade c term
  localparam int unsigned NS = 9;           // pipeline stages

  logic [NS-1:0] v_r;
  logic          adv;

  // pipe halts when the output register holds an untaken transaction
  assign adv     = !(v_r[NS-1] && out_stall);
  assign b_stall = !adv;

  always_ff @(posedge clk) begin
    if (!rst_n) v_r <= '0;
    else if (adv) v_r <= {v_r[NS-2:0], b_valid};
  end

  function automatic logic signed [VW-1:0] grad(input logic [3:0] h,
      input logic signed [TW-1:0] x, input logic signed [TW-1:0] y,
      input logic signed [TW-1:0] z);
    logic signed [VW-1:0] u, v;
    u = (h < 4'd8) ? VW'(x) : VW'(y);
    v = (h < 4'd4) ? VW'(y) : ((h == 4'd12 || h == 4'd14) ? VW'(x) : VW'(z));
    return (h[0] ? -u : u) + (h[1] ? -v : v);
  endfunction

  function automatic logic signed [VW-1:0] lerp_prod(
      input logic signed [VW-1:0] a, input logic signed [2*VW+1:0] p);
    logic signed [2*VW+1:0] s;
    s = p >>> F;
    return a + VW'(s);
  endfunction

  // stage 1: t*(6t-15), t*t ; gradients
  logic [F-1:0]           t1_r [3];
  logic signed [2*F+6:0]  q1_r [3];
  logic [2*F-1:0]         tt1_r [3];
  logic signed [VW-1:0]   g1_r [8];
  // stage 2: c, p
  logic [F-1:0]           t2_r [3];
  logic signed [CW-1:0]   c2_r [3];
  logic [F-1:0]           p2_r [3];
  logic signed [VW-1:0]   g2_r [8];
  // stage 3: p*t
  logic signed [CW-1:0]   c3_r [3];
  logic [2*F-1:0]         pt3_r [3];
  logic signed [VW-1:0]   g3_r [8];
  // stage 4: fade
  logic signed [2*F+5:0]  fd4_r [3];
  logic signed [VW-1:0]   g4_r [8];
  logic [F:0]             w5_r [2];
  // lerp levels: products then adds
  logic signed [2*VW+1:0] lp5_r [4];
  logic signed [VW-1:0]   la5_r [4];
  logic signed [VW-1:0]   l6_r [4];
  logic [F:0]             w6_r [2];
  logic signed [2*VW+1:0] lp7_r [2];
  logic signed [VW-1:0]   la7_r [2];
  logic [F:0]             w7_r;
  logic signed [VW-1:0]   l8_r [2];
  logic [F:0]             w8_r;
  logic signed [OutW-1:0] o9_r;

  logic [F-1:0]         tin [3];
  logic signed [TW-1:0] x0, y0, z0, x1, y1, z1;
  logic signed [VW-1:0] r8, res;
  logic signed [2*VW+1:0] p8;
  logic signed [VW+16:0] sc;

  assign tin[0] = b_fx;
  assign tin[1] = b_fy;
  assign tin[2] = b_fz;
  assign x0 = TW'({1'b0, b_fx});
  assign y0 = TW'({1'b0, b_fy});
  assign z0 = TW'({1'b0, b_fz});
  assign x1 = x0 - (TW'(1) <<< F);
  assign y1 = y0 - (TW'(1) <<< F);
  assign z1 = z0 - (TW'(1) <<< F);

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        t1_r[i]  <= tin[i];
        q1_r[i]  <= (2*F+7)'($signed({1'b0, tin[i]})) *
                    ((2*F+7)'($signed({3'b0, tin[i]})) * 6 - ((2*F+7)'(15) <<< F));
        tt1_r[i] <= tin[i] * tin[i];
        t2_r[i]  <= t1_r[i];
        c2_r[i]  <= CW'(q1_r[i] >>> F) + (CW'(10) <<< F);
        p2_r[i]  <= tt1_r[i][2*F-1:F];
        c3_r[i]  <= c2_r[i];
        pt3_r[i] <= p2_r[i] * t2_r[i];
        fd4_r[i] <= (2*F+6)'($signed({1'b0, pt3_r[i][2*F-1:F]})) * (2*F+6)'(c3_r[i]);
      end
      w5_r[0] <= (F+1)'(fd4_r[1] >>> F);
      w5_r[1] <= (F+1)'(fd4_r[2] >>> F);
      g1_r[0] <= grad(b_hash[0][3:0], x0, y0, z0);
      g1_r[1] <= grad(b_hash[1][3:0], x1, y0, z0);
      g1_r[2] <= grad(b_hash[2][3:0], x0, y1, z0);
      g1_r[3] <= grad(b_hash[3][3:0], x1, y1, z0);
      g1_r[4] <= grad(b_hash[4][3:0], x0, y0, z1);
      g1_r[5] <= grad(b_hash[5][3:0], x1, y0, z1);
      g1_r[6] <= grad(b_hash[6][3:0], x0, y1, z1);
      g1_r[7] <= grad(b_hash[7][3:0], x1, y1, z1);
      g2_r <= g1_r;
      g3_r <= g2_r;
      g4_r <= g3_r;
      // x lerps: the fade of x is ready at stage 4 output
      for (int k = 0; k < 4; k++) begin
        la5_r[k] <= g4_r[2*k];
        lp5_r[k] <= (2*VW+2)'($signed({1'b0, (F+1)'(fd4_r[0] >>> F)})) *
                    (2*VW+2)'(g4_r[2*k+1] - g4_r[2*k]);
        l6_r[k]  <= lerp_prod(la5_r[k], lp5_r[k]);
      end
      w6_r[0] <= w5_r[0];
      w6_r[1] <= w5_r[1];
      for (int k = 0; k < 2; k++) begin
        la7_r[k] <= l6_r[2*k];
        lp7_r[k] <= (2*VW+2)'($signed({1'b0, w6_r[0]})) *
                    (2*VW+2)'(l6_r[2*k+1] - l6_r[2*k]);
        l8_r[k]  <= lerp_prod(la7_r[k], lp7_r[k]);
      end
      w7_r <= w6_r[1];
      w8_r <= w7_r;
      o9_r <= OutW'(0) + res[OutW-1:0];
    end
  end

  // final z lerp, scaling and saturation
  assign p8 = (2*VW+2)'($signed({1'b0, w8_r})) * (2*VW+2)'(l8_r[1] - l8_r[0]);
  assign r8 = lerp_prod(l8_r[0], p8);

  always_comb begin
    if (F >= OutFrac) sc = (VW+17)'(r8) >>> (F - OutFrac);
    else              sc = (VW+17)'(r8) <<< (OutFrac - F);
    if (sc > (VW+17)'(131071))       res = VW'(131071);
    else if (sc < -(VW+17)'(131072)) res = -VW'(131072);
    else                             res = VW'(sc);
  end

  assign out_valid       = v_r[NS-1];
  assign out_noise_value = o9_r;

endmodule

[hw/rtl/gradient_noise_3d.sv]
// ----------------------------------------------------------------------------
// gradient_noise_3d: improved 3d gradient noise, one sample per transaction
// hash front end, decoupling queue, fade/gradient/lerp back end
// ----------------------------------------------------------------------------
//  channel | direction | ports
//  input   | in        | in_valid, in_stall, in_coord_x/y/z (24 bit unsigned)
//  result  | out       | out_valid, out_stall, out_noise_value (18 bit signed q2.16)
//
// one transaction per clock sustained while out_stall stays low; each transaction passes
// through the front pipe, then the queue, which registers it, then the back pipe
// rst_n is synchronous and clears only the valid pipeline and the queue pointers and count
// each side stalls on its own; the queue absorbs the front pipe on back stalls
module gradient_noise_3d import gn3_pkg::*; #(
  parameter int unsigned FRAC_BITS    = FracBitsDef
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [CoordW-1:0]      in_coord_x,
  input  logic [CoordW-1:0]      in_coord_y,
  input  logic [CoordW-1:0]      in_coord_z,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic signed [OutW-1:0] out_noise_value
);

  // packed transaction through the queue: three fractions and 8 hashes
  localparam int unsigned HW = 8*LatticeBitsDef;
  localparam int unsigned QW = 3*FRAC_BITS + HW;

  logic                 f_valid, f_stall, q_valid, q_stall;
  logic [FRAC_BITS-1:0] f_fx, f_fy, f_fz, q_fx, q_fy, q_fz;
  logic [7:0]           f_hash [8];
  logic [7:0]           q_hash [8];
  logic [QW-1:0]        f_pack, q_pack;

  gn3_front #(.FRAC_BITS(FRAC_BITS)) u_front (
    .clk, .rst_n, .in_valid, .in_stall, .in_coord_x, .in_coord_y, .in_coord_z,
    .f_valid, .f_stall, .f_fx, .f_fy, .f_fz, .f_hash
  );

  always_comb begin
    f_pack = {f_fx, f_fy, f_fz, HW'(0)};
    for (int i = 0; i < 8; i++) f_pack[i*8 +: 8] = f_hash[i];
    {q_fx, q_fy, q_fz} = q_pack[QW-1 -: 3*FRAC_BITS];
    for (int i = 0; i < 8; i++) q_hash[i] = q_pack[i*8 +: 8];
  end

  gn3_queue #(.W(QW), .DEPTH(QueueDepth)) u_queue (
    .clk, .rst_n,
    .wr_valid(f_valid), .wr_stall(f_stall), .wr_data(f_pack),
    .rd_valid(q_valid), .rd_stall(q_stall), .rd_data(q_pack)
  );

  gn3_back #(.FRAC_BITS(FRAC_BITS)) u_back (
    .clk, .rst_n,
    .b_valid(q_valid), .b_stall(q_stall),
    .b_fx(q_fx), .b_fy(q_fy), .b_fz(q_fz), .b_hash(q_hash),
    .out_valid, .out_stall, .out_noise_value
  );

endmodule

[bench/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for gradient_noise_3d
// drives sample points with random gaps, predicts each noise value in
// fixed point, and checks every result transaction in order
// ----------------------------------------------------------------------------
module tb import gn3_pkg::*; ();

  localparam int unsigned FB = FracBitsDef;

  logic                   clk;
  logic                   rst_n;
  logic                   in_valid;
  logic                   in_stall;
  logic [CoordW-1:0]      in_coord_x;
  logic [CoordW-1:0]      in_coord_y;
  logic [CoordW-1:0]      in_coord_z;
  logic                   out_valid;
  logic                   out_stall;
  logic signed [OutW-1:0] out_noise_value;

  // expected noise values, oldest first
  logic signed [OutW-1:0] noise_q[$];
  int                     errors;
  bit                     hold_off;      // long receiver stall requested
  bit                     rx_random;     // receiver draws random stalls

  gradient_noise_3d uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_coord_x(in_coord_x), .in_coord_y(in_coord_y), .in_coord_z(in_coord_z),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_noise_value(out_noise_value)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // run limit, far above the slowest legal run
  initial begin
    #20ms;
    $display("status: fail");
    $finish;
  end

  // ---------------------------------------------------------------- predictor
  // floor shift; >>> on signed longint already rounds toward minus infinity
  function automatic longint shr_floor(longint v);
    return v >>> FB;
  endfunction

  // quintic fade 6t^5-15t^4+10t^3 in q0.16
  function automatic longint fade_weight(longint t);
    longint one, c, p;
    one = longint'(1) << FB;
    c = shr_floor(t * (6 * t - 15 * one)) + 10 * one;
    p = shr_floor(t * t);
    p = shr_floor(p * t);
    return shr_floor(p * c);
  endfunction

  function automatic longint blend(longint w, longint a, longint b);
    return a + shr_floor(w * (b - a));
  endfunction

  // one of 12 gradient directions from the low 4 hash bits
  function automatic longint grad_dot(logic [7:0] hv, longint x, longint y, longint z);
    logic [3:0] h;
    longint     u, v;
    h = hv[3:0];
    u = (h < 8) ? x : y;
    v = (h < 4) ? y : ((h == 12 || h == 14) ? x : z);
    return (h[0] ? -u : u) + (h[1] ? -v : v);
  endfunction

  function automatic logic signed [OutW-1:0] noise_at(logic [CoordW-1:0] cx,
      logic [CoordW-1:0] cy, logic [CoordW-1:0] cz);
    logic [7:0] cxi, cyi, czi, a, b, aa, ab, ba, bb;
    longint     x, y, z, x1, y1, z1, u, v, w, one, r;
    one = longint'(1) << FB;
    // cell index wraps mod 256 as 8-bit vectors do
    cxi = cx[FB +: 8]; cyi = cy[FB +: 8]; czi = cz[FB +: 8];
    x = cx[FB-1:0]; y = cy[FB-1:0]; z = cz[FB-1:0];
    x1 = x - one; y1 = y - one; z1 = z - one;
    u = fade_weight(x); v = fade_weight(y); w = fade_weight(z);
    a  = perm(cxi) + cyi;       b  = perm(cxi + 8'd1) + cyi;
    aa = perm(a) + czi;         ab = perm(a + 8'd1) + czi;
    ba = perm(b) + czi;         bb = perm(b + 8'd1) + czi;
    r = blend(w,
          blend(v,
            blend(u, grad_dot(perm(aa), x, y, z), grad_dot(perm(ba), x1, y, z)),
            blend(u, grad_dot(perm(ab), x, y1, z), grad_dot(perm(bb), x1, y1, z))),
          blend(v,
            blend(u, grad_dot(perm(aa + 8'd1), x, y, z1),
                     grad_dot(perm(ba + 8'd1), x1, y, z1)),
            blend(u, grad_dot(perm(ab + 8'd1), x, y1, z1),
                     grad_dot(perm(bb + 8'd1), x1, y1, z1))));
    // saturate to q2.16
    if (r > 131071) r = 131071;
    if (r < -131072) r = -131072;
    return r[OutW-1:0];
  endfunction

  // ---------------------------------------------------------------- driver
  // offer one sample point, wait for its acceptance, record the expectation
  // valid stays high into the next transaction when there is no gap
  task automatic send_point(logic [CoordW-1:0] x, logic [CoordW-1:0] y,
      logic [CoordW-1:0] z, int gap);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_coord_x <= x;
    in_coord_y <= y;
    in_coord_z <= z;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    // transaction taken at this edge
    noise_q.push_back(noise_at(x, y, z));
  endtask

  task automatic send_back_to_back(logic [CoordW-1:0] x, logic [CoordW-1:0] y,
      logic [CoordW-1:0] z);
    send_point(x, y, z, 0);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (noise_q.size() != 0) @(posedge clk);
  endtask

  // ---------------------------------------------------------------- receiver
  // a random stall drawn per result, with a long hold-off on demand
  initial begin : stall_gen
    int n;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off) begin
        out_stall <= 1'b1;
        repeat (200) @(posedge clk);
        out_stall <= 1'b0;
        hold_off = 1'b0;
      end else if (rx_random && !out_stall && out_valid) begin
        n = $urandom_range(0, 9);
        if (n > 0) begin
          out_stall <= 1'b1;
          repeat (n) @(posedge clk);
          out_stall <= 1'b0;
        end
      end
    end
  end

  // result checker: compare each accepted transaction with the oldest one due
  always @(posedge clk) begin
    logic signed [OutW-1:0] want;
    if (rst_n && out_valid && !out_stall) begin
      if (noise_q.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %0d", $time,
                 out_noise_value);
        errors++;
      end else begin
        want = noise_q.pop_front();
        if (out_noise_value !== want) begin
          $display("%0t: noise_value mismatch, expected %0d, actual %0d", $time,
                   want, out_noise_value);
          errors++;
        end
      end
    end
  end

  // ---------------------------------------------------------------- tests
  // lattice corners, coordinate extremes, exact integers and wrap of the cell
  task automatic test_directed();
    logic [CoordW-1:0] ext[6];
    ext = '{24'h000000, 24'hFFFFFF, 24'h010000, 24'h00FFFF, 24'h800000, 24'h7F8000};
    for (int i = 0; i < 6; i++)
      send_point(ext[i], ext[(i + 1) % 6], ext[(i + 3) % 6], 0);
    send_point(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 1);
    send_point(24'h000000, 24'h000000, 24'h000000, 0);
    // exact integer points give zero noise
    send_point(24'h050000, 24'h0A0000, 24'hFF0000, 0);
    // points at fractions of one half, one quarter and three quarters over several cells
    for (int i = 0; i < 12; i++)
      send_point({8'(i * 21), 16'h8000}, {8'(i * 7), 16'h4000}, {8'(i * 33), 16'hC000}, 0);
    wait_drained();
  endtask

  // random points, random gaps on the sender and stalls on the receiver
  task automatic test_random(int count);
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 3) == 0)
        send_point(CoordW'($urandom), CoordW'($urandom), CoordW'($urandom), 0);
      else
        send_point(CoordW'($urandom), CoordW'($urandom), CoordW'($urandom),
                   $urandom_range(0, 9));
    end
    wait_drained();
  endtask

  // full rate stream with no idling on either side
  task automatic test_full_rate();
    rx_random = 1'b0;
    for (int i = 0; i < 80; i++)
      send_back_to_back(CoordW'($urandom), CoordW'($urandom), CoordW'($urandom));
    wait_drained();
    rx_random = 1'b1;
  endtask

  // receiver holds off long enough for the block to stall its input
  task automatic test_backpressure();
    hold_off = 1'b1;
    for (int i = 0; i < 60; i++)
      send_back_to_back(CoordW'($urandom), CoordW'($urandom), CoordW'($urandom));
    // sender pauses here until every result has come
    wait_drained();
  endtask

  initial begin
    errors     = 0;
    hold_off   = 1'b0;
    rx_random  = 1'b1;
    rst_n      <= 1'b0;
    in_valid   <= 1'b0;
    in_coord_x <= '0;
    in_coord_y <= '0;
    in_coord_z <= '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_full_rate();
    test_backpressure();
    test_random(600);
    // let the pipe settle after the last result
    repeat (40) @(posedge clk);
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

[filelist.f]
hw/rtl/gn3_pkg.sv
hw/rtl/gn3_front.sv
hw/rtl/gn3_queue.sv
hw/rtl/gn3_back.sv
hw/rtl/gradient_noise_3d.sv
bench/tb.sv
